// File: sv/cils_pkg.sv
package cils_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // suffix flag bits
  localparam logic [2:0] SfU  = 3'b001;
  localparam logic [2:0] SfL  = 3'b010;
  localparam logic [2:0] SfLl = 3'b100;

  // result type codes
  localparam logic [2:0] TyInt   = 3'd0;
  localparam logic [2:0] TyUint  = 3'd1;
  localparam logic [2:0] TyLong  = 3'd2;
  localparam logic [2:0] TyUlong = 3'd3;
  localparam logic [2:0] TyLl    = 3'd4;
  localparam logic [2:0] TyUll   = 3'd5;

  typedef struct packed {
    logic        found;
    logic [5:0]  length;
    logic [63:0] value;
    logic [2:0]  sflags;
    logic        wrap;
    logic        too_long;
  } scan_rec_t;

endpackage

// File: sv/cils_front.sv
module cils_front import cils_pkg::*; #(
  parameter int unsigned LEN_CAP = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       start_req_i,
  input  logic       space_i,
  output logic [1:0] push_cnt_o,
  output scan_rec_t  push_rec0_o,
  output scan_rec_t  push_rec1_o
);

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhZero   = 4'd1;
  localparam logic [3:0] PhHexpre = 4'd2;
  localparam logic [3:0] PhHex    = 4'd3;
  localparam logic [3:0] PhOct    = 4'd4;
  localparam logic [3:0] PhDec    = 4'd5;
  localparam logic [3:0] PhU      = 4'd6;
  localparam logic [3:0] PhUl     = 4'd7;
  localparam logic [3:0] PhL      = 4'd8;
  localparam logic [3:0] PhLl     = 4'd9;
  localparam logic [3:0] PhEnd    = 4'd10;

  localparam logic [5:0] Cap = 6'(LEN_CAP);

  logic [3:0]  phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [5:0]  count_q, count_d;
  logic [2:0]  sf_q, sf_d;
  logic        wrap_q, wrap_d;

  logic        fire;
  logic        is_oct, is_dec, is_hex, is_u, is_l, is_x, body;
  logic [3:0]  hex_v;
  logic [67:0] dec_sum;
  logic        ext_ok;
  logic [3:0]  phase_x;
  logic [63:0] acc_x;
  logic [2:0]  sf_x;
  logic        wrap_x;
  scan_rec_t   cur_rec;
  logic [1:0]  n;

  assign in_stall_o = !space_i;
  assign fire       = in_valid_i && space_i;

  always_comb begin
    is_oct = ch_i inside {[8'd48:8'd55]};
    is_dec = ch_i inside {[8'd48:8'd57]};
    is_u   = (ch_i == "u") || (ch_i == "U");
    is_l   = (ch_i == "l") || (ch_i == "L");
    is_x   = (ch_i == "x") || (ch_i == "X");
    is_hex = 1'b1;
    hex_v  = ch_i[3:0];
    if (ch_i inside {[8'd65:8'd70]}) begin
      hex_v = 4'(ch_i - 8'd55);
    end else if (ch_i inside {[8'd97:8'd102]}) begin
      hex_v = 4'(ch_i - 8'd87);
    end else if (!is_dec) begin
      is_hex = 1'b0;
    end
    body = (phase_q == PhZero) || (phase_q == PhOct) || (phase_q == PhDec) ||
           (phase_q == PhHex);
  end

  assign dec_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, ch_i[3:0]};

  always_comb begin
    ext_ok  = 1'b1;
    phase_x = phase_q;
    acc_x   = acc_q;
    sf_x    = sf_q;
    wrap_x  = wrap_q;
    if (phase_q == PhZero && is_x) begin
      phase_x = PhHexpre;
    end else if ((phase_q == PhZero || phase_q == PhOct) && is_oct) begin
      acc_x   = {acc_q[60:0], ch_i[2:0]};
      wrap_x  = wrap_q | (|acc_q[63:61]);
      phase_x = PhOct;
    end else if (phase_q == PhDec && is_dec) begin
      acc_x  = dec_sum[63:0];
      wrap_x = wrap_q | (|dec_sum[67:64]);
    end else if ((phase_q == PhHexpre || phase_q == PhHex) && is_hex) begin
      acc_x   = {acc_q[59:0], hex_v};
      wrap_x  = wrap_q | (|acc_q[63:60]);
      phase_x = PhHex;
    end else if (body && is_u) begin
      sf_x    = SfU;
      phase_x = PhU;
    end else if (body && is_l) begin
      sf_x    = SfL;
      phase_x = PhL;
    end else if (phase_q == PhU && is_l) begin
      sf_x    = SfU | SfL;
      phase_x = PhUl;
    end else if (phase_q == PhUl && is_l) begin
      sf_x    = SfU | SfLl;
      phase_x = PhEnd;
    end else if (phase_q == PhL && is_l) begin
      sf_x    = SfLl;
      phase_x = PhLl;
    end else if (phase_q == PhLl && is_u) begin
      sf_x    = SfLl | SfU;
      phase_x = PhEnd;
    end else begin
      ext_ok = 1'b0;
    end
  end

  always_comb begin
    cur_rec.found    = 1'b1;
    cur_rec.length   = count_q;
    cur_rec.value    = acc_q;
    cur_rec.sflags   = sf_q;
    cur_rec.wrap     = wrap_q;
    cur_rec.too_long = (count_q >= Cap);
  end

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    count_d     = count_q;
    sf_d        = sf_q;
    wrap_d      = wrap_q;
    n           = 2'd0;
    push_rec0_o = '0;
    // a second record in one transaction is always a failed start
    push_rec1_o = '0;
    if (fire) begin
      if (phase_q != PhIdle) begin
        if (!start_req_i && ext_ok) begin
          phase_d = phase_x;
          acc_d   = acc_x;
          sf_d    = sf_x;
          wrap_d  = wrap_x;
          count_d = (count_q < Cap) ? count_q + 6'd1 : count_q;
        end else begin
          if (phase_q != PhHexpre) begin
            push_rec0_o = cur_rec;
          end
          n       = 2'd1;
          phase_d = PhIdle;
          acc_d   = '0;
          count_d = '0;
          sf_d    = '0;
          wrap_d  = 1'b0;
        end
      end
      if (start_req_i) begin
        if (ch_i inside {[8'd49:8'd57]}) begin
          phase_d = PhDec;
          acc_d   = {60'd0, ch_i[3:0]};
          count_d = 6'd1;
        end else if (ch_i == 8'd48) begin
          phase_d = PhZero;
          count_d = 6'd1;
        end else begin
          n = n + 2'd1;
        end
      end
    end
  end

  assign push_cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      count_q <= '0;
      sf_q    <= '0;
      wrap_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      count_q <= count_d;
      sf_q    <= sf_d;
      wrap_q  <= wrap_d;
    end
  end

endmodule

// File: sv/cils_queue.sv
module cils_queue import cils_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] push_cnt_i,
  input  scan_rec_t push_rec0_i,
  input  scan_rec_t push_rec1_i,
  output logic      space_o,
  output logic      head_valid_o,
  output scan_rec_t head_o,
  input  logic      pop_i
);

  scan_rec_t        rec_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign space_o      = (count_q <= QCntW'(QDepth - 2));
  assign head_valid_o = (count_q != '0);
  assign head_o       = rec_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QPtrW'(do_pop);
    count_d  = count_q + QCntW'(push_cnt_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      rec_q[wr_ptr_q] <= push_rec0_i;
    end
    if (push_cnt_i == 2'd2) begin
      rec_q[wr_ptr_q + QPtrW'(1)] <= push_rec1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: sv/cils_back.sv
module cils_back import cils_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        head_valid_i,
  input  scan_rec_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [5:0]  length_o,
  output logic [63:0] value_o,
  output logic [2:0]  type_code_o,
  output logic        overflowed_o,
  output logic        too_long_o
);

  logic        wide_q;
  logic        valid_q;
  logic        found_q, ovf_q, tl_q;
  logic [5:0]  len_q;
  logic [63:0] val_q;
  logic [2:0]  ty_q, ty_d;
  logic        fits_int, fits_uint, fits_long, fits_ulong;
  logic        load;

  always_comb begin
    fits_int   = (head_i.value[63:31] == '0);
    fits_uint  = (head_i.value[63:32] == '0);
    fits_long  = wide_q ? !head_i.value[63] : fits_int;
    fits_ulong = wide_q ? 1'b1 : fits_uint;
    if ((head_i.sflags & SfLl) != '0) begin
      ty_d = ((head_i.sflags & SfU) != '0) ? TyUll : TyLl;
    end else if ((head_i.sflags & SfL) != '0) begin
      if ((head_i.sflags & SfU) != '0) begin
        ty_d = fits_ulong ? TyUlong : TyUll;
      end else begin
        ty_d = fits_long ? TyLong : TyLl;
      end
    end else if ((head_i.sflags & SfU) != '0) begin
      ty_d = fits_uint ? TyUint : (fits_ulong ? TyUlong : TyUll);
    end else begin
      ty_d = fits_int ? TyInt : (fits_long ? TyLong : TyLl);
    end
    // failed scans report every field as zero
    if (!head_i.found) begin
      ty_d = TyInt;
    end
  end

  assign load  = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q <= head_i.found;
      len_q   <= head_i.length;
      val_q   <= head_i.value;
      ty_q    <= ty_d;
      ovf_q   <= head_i.wrap;
      tl_q    <= head_i.too_long;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wide_q  <= 1'b1;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        wide_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign found_o      = found_q;
  assign length_o     = len_q;
  assign value_o      = val_q;
  assign type_code_o  = ty_q;
  assign overflowed_o = ovf_q;
  assign too_long_o   = tl_q;

endmodule

// File: sv/c_integer_literal_scanner.sv
// results pass through the queue and are then loaded into the output register
// throughput: one character per cycle while in_stall_o is low; a character
//   that closes one scan and fails a new start queues two results, drained
//   one per cycle by the back end while out_stall_i is low
// reset: scanner idle, queue empty, output invalid, long_is_wide set to 1
module c_integer_literal_scanner import cils_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [5:0]  length_o,
  output logic [63:0] value_o,
  output logic [2:0]  type_code_o,
  output logic        overflowed_o,
  output logic        too_long_o
);

  localparam int unsigned LenCap = (MAX_LENGTH < 63) ? MAX_LENGTH : 63;

  logic [1:0] push_cnt;
  logic       q_space;
  scan_rec_t  rec0, rec1, head;
  logic       head_valid, pop;

  cils_front #(
    .LEN_CAP(LenCap)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .space_i     (q_space),
    .push_cnt_o  (push_cnt),
    .push_rec0_o (rec0),
    .push_rec1_o (rec1)
  );

  cils_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (push_cnt),
    .push_rec0_i  (rec0),
    .push_rec1_i  (rec1),
    .space_o      (q_space),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  cils_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .length_o     (length_o),
    .value_o      (value_o),
    .type_code_o  (type_code_o),
    .overflowed_o (overflowed_o),
    .too_long_o   (too_long_o)
  );

endmodule
